// File: design/dafe_pkg.sv
// ----------------------------------------------------------------------------
// dafe_pkg
// Shared types and constants for the decimal ASCII frame encoder.
// ----------------------------------------------------------------------------
package dafe_pkg;

    localparam int VALUE_W   = 16;
    localparam int CHAR_W    = 7;
    localparam int MAG_W     = 14;
    localparam int NDIG_W    = 3;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_START = 7'h40;
    localparam logic [CHAR_W-1:0] CH_END   = 7'h24;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

    localparam logic [MAG_W-1:0] SAT_MAX = 14'd9999;

    // One classified value: four BCD digits (index 0 is the units) and the
    // number of digits to send, zero for a negative value.
    typedef struct packed {
        logic [3:0][3:0]    digits;
        logic [NDIG_W-1:0]  n_dig;
    } t_frame;

endpackage

// File: design/dafe_front.sv
// ----------------------------------------------------------------------------
// dafe_front
// Accepts values, saturates them and splits them into decimal digits over
// three pipeline stages: thousands, then hundreds, then tens and units.
// ----------------------------------------------------------------------------
module dafe_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dafe_pkg::VALUE_W-1:0] i_value,
    output logic                                o_push,
    input  logic                                i_push_ready,
    output dafe_pkg::t_frame                    o_frame
);

    // Largest k up to nine with k times the weight not above the value, by parallel compares.
    function automatic logic [3:0] get_digit(
        input logic [dafe_pkg::MAG_W-1:0] v,
        input logic [dafe_pkg::MAG_W-1:0] w
    );
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= dafe_pkg::MAG_W'(k) * w) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    logic                           en;
    logic [dafe_pkg::MAG_W-1:0]     sat_val;
    logic [dafe_pkg::NDIG_W-1:0]    ndig;
    logic [3:0]                     dig_a;
    logic [3:0]                     dig_b;
    logic [3:0]                     dig_c;
    logic [dafe_pkg::MAG_W-1:0]     rem_a;
    logic [dafe_pkg::MAG_W-1:0]     rem_b;
    logic [dafe_pkg::MAG_W-1:0]     rem_c;

    logic                           r_a_valid;
    logic                           r_b_valid;
    logic                           r_c_valid;
    logic [9:0]                     r_a_rem;
    logic [6:0]                     r_b_rem;
    logic [3:0]                     r_a_d3;
    logic [3:0]                     r_b_d3;
    logic [3:0]                     r_b_d2;
    logic [dafe_pkg::NDIG_W-1:0]    r_a_n;
    logic [dafe_pkg::NDIG_W-1:0]    r_b_n;
    dafe_pkg::t_frame               r_c_frame;

    // The whole pipeline stalls only when its last stage cannot push.
    assign en      = !r_c_valid || i_push_ready;
    assign o_ready = en;
    assign o_push  = r_c_valid;
    assign o_frame = r_c_frame;

    always_comb begin
        if (i_value[14:0] > 15'(dafe_pkg::SAT_MAX)) begin
            sat_val = dafe_pkg::SAT_MAX;
        end else begin
            sat_val = i_value[dafe_pkg::MAG_W-1:0];
        end
        priority if (i_value[dafe_pkg::VALUE_W-1]) begin
            ndig = 3'd0;
        end else if (sat_val >= 14'd1000) begin
            ndig = 3'd4;
        end else if (sat_val >= 14'd100) begin
            ndig = 3'd3;
        end else if (sat_val >= 14'd10) begin
            ndig = 3'd2;
        end else begin
            ndig = 3'd1;
        end
        dig_a = get_digit(sat_val, 14'd1000);
        rem_a = sat_val - dafe_pkg::MAG_W'(dig_a) * 14'd1000;
        dig_b = get_digit(dafe_pkg::MAG_W'(r_a_rem), 14'd100);
        rem_b = dafe_pkg::MAG_W'(r_a_rem) - dafe_pkg::MAG_W'(dig_b) * 14'd100;
        dig_c = get_digit(dafe_pkg::MAG_W'(r_b_rem), 14'd10);
        rem_c = dafe_pkg::MAG_W'(r_b_rem) - dafe_pkg::MAG_W'(dig_c) * 14'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rem   <= rem_a[9:0];
            r_a_d3    <= dig_a;
            r_a_n     <= ndig;
            r_b_rem   <= rem_b[6:0];
            r_b_d3    <= r_a_d3;
            r_b_d2    <= dig_b;
            r_b_n     <= r_a_n;
            r_c_frame <= '{digits: {r_b_d3, r_b_d2, dig_c, rem_c[3:0]}, n_dig: r_b_n};
        end
    end

endmodule

// File: design/dafe_queue.sv
// ----------------------------------------------------------------------------
// dafe_queue
// Short register FIFO of classified values between front and back.
// ----------------------------------------------------------------------------
module dafe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  dafe_pkg::t_frame i_frame,
    output logic             o_valid,
    input  logic             i_pop,
    output dafe_pkg::t_frame o_frame
);

    dafe_pkg::t_frame              r_mem [dafe_pkg::QDEPTH];
    logic [dafe_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [dafe_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [dafe_pkg::QCNT_W-1:0]   r_count;
    logic                          wr_en;
    logic                          rd_en;

    assign o_push_ready = r_count != dafe_pkg::QCNT_W'(dafe_pkg::QDEPTH);
    assign o_valid      = r_count != '0;
    assign o_frame      = r_mem[r_rd_ptr];
    assign wr_en        = i_push && o_push_ready;
    assign rd_en        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == dafe_pkg::QPTR_W'(dafe_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == dafe_pkg::QPTR_W'(dafe_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// File: design/dafe_back.sv
// ----------------------------------------------------------------------------
// dafe_back
// Sequences one classified value into its character run through an output
// register.
// ----------------------------------------------------------------------------
module dafe_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  dafe_pkg::t_frame             i_q_frame,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dafe_pkg::CHAR_W-1:0]  o_out_char,
    output logic                         o_last
);

    logic                           r_busy;
    logic [2:0]                     r_pos;
    dafe_pkg::t_frame               r_item;
    logic                           r_out_valid;
    logic [dafe_pkg::CHAR_W-1:0]    r_out_char;
    logic                           r_out_last;

    logic                           n_busy;
    logic [2:0]                     n_pos;
    dafe_pkg::t_frame               n_item;
    logic                           n_out_valid;
    logic [dafe_pkg::CHAR_W-1:0]    n_out_char;
    logic                           n_out_last;
    logic                           adv;
    logic [1:0]                     dig_idx;

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

    assign adv     = !r_out_valid || i_ready;
    // Digits go out most significant first; position one is the top digit.
    assign dig_idx = 2'(r_item.n_dig - r_pos);

    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        if (adv) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                if (r_pos <= r_item.n_dig) begin
                    n_out_char = dafe_pkg::CH_ZERO + dafe_pkg::CHAR_W'(r_item.digits[dig_idx]);
                    n_out_last = 1'b0;
                    n_pos      = r_pos + 3'd1;
                end else begin
                    n_out_char = dafe_pkg::CH_END;
                    n_out_last = 1'b1;
                    n_busy     = 1'b0;
                end
            end else if (i_q_valid) begin
                o_q_pop     = 1'b1;
                n_item      = i_q_frame;
                n_busy      = 1'b1;
                n_pos       = 3'd1;
                n_out_valid = 1'b1;
                n_out_char  = dafe_pkg::CH_START;
                n_out_last  = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 3'd0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

// File: design/decimal_ascii_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// decimal_ascii_frame_encoder_top
// Turns signed 16-bit values into framed ASCII decimal character runs.
// ----------------------------------------------------------------------------
// Each accepted word gives the run '@', the decimal digits without leading
// zeros ('0' for zero), then '$' flagged as last; a negative value gives
// "@$" and values above 9999 are sent as 9999. The output side sets the
// pace: a value with n digits gives a run of n + 2 characters, two to six
// per word, and runs follow each other without gaps while the queue holds
// the next word. A three-stage digit pipeline in front and a two-entry
// queue let new words be taken while a run is still going out; a taken word
// passes the pipeline and the queue before its start character goes out.
module decimal_ascii_frame_encoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dafe_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dafe_pkg::CHAR_W-1:0]         o_out_char,
    output logic                                o_last
);

    logic             push;
    logic             push_ready;
    dafe_pkg::t_frame push_frame;
    logic             q_valid;
    logic             q_pop;
    dafe_pkg::t_frame q_frame;

    dafe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_frame      (push_frame)
    );

    dafe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_frame      (push_frame),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_frame      (q_frame)
    );

    dafe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_frame  (q_frame),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
